// ===== hdl/pmwq_pkg.sv =====
// ----------------------------------------------------------------------------
// pmwq_pkg - shared types and codes of the priority mutex wait queue
// Request kinds, result status codes and the control bundle to the cells.
// ----------------------------------------------------------------------------
package pmwq_pkg;

  localparam logic KIND_LOCK   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  localparam int STATUS_BITS = 3;
  typedef logic [STATUS_BITS-1:0] status_t;

  localparam status_t ST_GRANTED    = 3'd0;
  localparam status_t ST_QUEUED     = 3'd1;
  localparam status_t ST_FREED      = 3'd2;
  localparam status_t ST_HANDED     = 3'd3;
  localparam status_t ST_UNBALANCED = 3'd4;
  localparam status_t ST_FULL       = 3'd5;

  typedef struct packed {
    logic insert;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== hdl/pmwq_cell.sv =====
// ----------------------------------------------------------------------------
// pmwq_cell - one waiter slot of the wait chain
// Holds one waiter, kept newest-first along the chain. Takes its neighbor's
// waiter on an insert while every cell before it is in use, and passes the
// best waiter seen so far on to the next cell through a register.
// ----------------------------------------------------------------------------
module pmwq_cell #(
  parameter int CELL_IDX  = 0,
  parameter int ID_BITS   = 8,
  parameter int PRIO_BITS = 8,
  parameter int IDX_BITS  = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pmwq_pkg::cell_ctrl_t     ctrl,
  input  logic [IDX_BITS-1:0]      clear_idx,
  input  logic                     prefix_in,
  output logic                     prefix_out,
  input  logic                     nbr_valid,
  input  logic [ID_BITS-1:0]       nbr_id,
  input  logic [PRIO_BITS-1:0]     nbr_prio,
  output logic                     valid,
  output logic [ID_BITS-1:0]       id,
  output logic [PRIO_BITS-1:0]     prio,
  input  logic                     cand_in_valid,
  input  logic [ID_BITS-1:0]       cand_in_id,
  input  logic [PRIO_BITS-1:0]     cand_in_prio,
  input  logic [IDX_BITS-1:0]      cand_in_idx,
  output logic                     cand_out_valid,
  output logic [ID_BITS-1:0]       cand_out_id,
  output logic [PRIO_BITS-1:0]     cand_out_prio,
  output logic [IDX_BITS-1:0]      cand_out_idx
);
  import pmwq_pkg::*;

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;
  logic                 cand_valid_r, cand_valid_nxt;
  logic [ID_BITS-1:0]   cand_id_r, cand_id_nxt;
  logic [PRIO_BITS-1:0] cand_prio_r, cand_prio_nxt;
  logic [IDX_BITS-1:0]  cand_idx_r, cand_idx_nxt;
  logic                 take_self;

  assign prefix_out = prefix_in & valid_r;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    if (ctrl.insert && prefix_in) begin
      valid_nxt = nbr_valid;
      id_nxt    = nbr_id;
      prio_nxt  = nbr_prio;
    end else if (ctrl.clear && (clear_idx == MY_IDX)) begin
      valid_nxt = 1'b0;
    end
  end

  // newer waiters sit earlier, so only a strictly higher priority replaces
  assign take_self = valid_r && (!cand_in_valid || (prio_r > cand_in_prio));

  always_comb begin
    if (take_self) begin
      cand_valid_nxt = 1'b1;
      cand_id_nxt    = id_r;
      cand_prio_nxt  = prio_r;
      cand_idx_nxt   = MY_IDX;
    end else begin
      cand_valid_nxt = cand_in_valid;
      cand_id_nxt    = cand_in_id;
      cand_prio_nxt  = cand_in_prio;
      cand_idx_nxt   = cand_in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      cand_valid_r <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      cand_valid_r <= cand_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    prio_r      <= prio_nxt;
    cand_id_r   <= cand_id_nxt;
    cand_prio_r <= cand_prio_nxt;
    cand_idx_r  <= cand_idx_nxt;
  end

  assign valid          = valid_r;
  assign id             = id_r;
  assign prio           = prio_r;
  assign cand_out_valid = cand_valid_r;
  assign cand_out_id    = cand_id_r;
  assign cand_out_prio  = cand_prio_r;
  assign cand_out_idx   = cand_idx_r;

endmodule

// ===== hdl/priority_mutex_wait_queue.sv =====
// ----------------------------------------------------------------------------
// priority_mutex_wait_queue - hardware mutex with a priority wait chain
// Grants, queues and hands over ownership; wakes the most urgent waiter.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries lock and unlock requests (kind, thread id,
//   priority); the out_ channel returns one item per request: a status code
//   and, for a hand-over, the id of the woken thread.
//   A lock, a failing unlock or a freeing unlock returns its item in the cycle
//   after acceptance. An unlock that hands the mutex to a waiter first scans
//   the chain: the best candidate travels one cell per cycle along the chain
//   of waiter cells, and the result is registered when it reaches the end.
//   One request is worked on at a time; the next is accepted when the block is
//   idle and the result register is free or being taken, not while a result waits.
//   When the receiver stalls, the result holds in the output register and
//   in_ready drops until it is taken.
//   Reset empties the wait chain and frees the mutex; no clearing pass.
// ----------------------------------------------------------------------------
module priority_mutex_wait_queue #(
  parameter int MAX_WAITERS = 16,
  parameter int ID_BITS     = 8,
  parameter int PRIO_BITS   = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_kind,
  input  logic [ID_BITS-1:0]       in_thread_id,
  input  logic [PRIO_BITS-1:0]     in_thread_priority,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pmwq_pkg::status_t        out_status,
  output logic [ID_BITS-1:0]       out_woken_thread
);
  import pmwq_pkg::*;

  localparam int IDX_BITS  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int HOLD_BITS = $clog2(MAX_WAITERS + 2);
  localparam int CNT_BITS  = $clog2(MAX_WAITERS + 1);
  localparam logic [CNT_BITS-1:0]  SCAN_LEN = CNT_BITS'(MAX_WAITERS);
  localparam logic [HOLD_BITS-1:0] HOLD_ONE = HOLD_BITS'(1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state_r, state_nxt;
  logic [HOLD_BITS-1:0] hold_r, hold_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic [ID_BITS-1:0]   woken_r, woken_nxt;

  logic accept, out_free, full, scan_done;
  cell_ctrl_t ctrl;

  logic [MAX_WAITERS:0]   prefix;
  logic [MAX_WAITERS:0]   ch_valid;
  logic [ID_BITS-1:0]     ch_id   [MAX_WAITERS+1];
  logic [PRIO_BITS-1:0]   ch_prio [MAX_WAITERS+1];
  logic [MAX_WAITERS:0]   cd_valid;
  logic [ID_BITS-1:0]     cd_id   [MAX_WAITERS+1];
  logic [PRIO_BITS-1:0]   cd_prio [MAX_WAITERS+1];
  logic [IDX_BITS-1:0]    cd_idx  [MAX_WAITERS+1];

  assign prefix[0]   = 1'b1;
  assign ch_valid[0] = 1'b1;
  assign ch_id[0]    = in_thread_id;
  assign ch_prio[0]  = in_thread_priority;
  assign cd_valid[0] = 1'b0;
  assign cd_id[0]    = '0;
  assign cd_prio[0]  = '0;
  assign cd_idx[0]   = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_WAITERS; g++) begin : g_cell
      pmwq_cell #(
        .CELL_IDX  (g),
        .ID_BITS   (ID_BITS),
        .PRIO_BITS (PRIO_BITS),
        .IDX_BITS  (IDX_BITS)
      ) u_cell (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .clear_idx      (cd_idx[MAX_WAITERS]),
        .prefix_in      (prefix[g]),
        .prefix_out     (prefix[g+1]),
        .nbr_valid      (ch_valid[g]),
        .nbr_id         (ch_id[g]),
        .nbr_prio       (ch_prio[g]),
        .valid          (ch_valid[g+1]),
        .id             (ch_id[g+1]),
        .prio           (ch_prio[g+1]),
        .cand_in_valid  (cd_valid[g]),
        .cand_in_id     (cd_id[g]),
        .cand_in_prio   (cd_prio[g]),
        .cand_in_idx    (cd_idx[g]),
        .cand_out_valid (cd_valid[g+1]),
        .cand_out_id    (cd_id[g+1]),
        .cand_out_prio  (cd_prio[g+1]),
        .cand_out_idx   (cd_idx[g+1])
      );
    end
  endgenerate

  assign full      = prefix[MAX_WAITERS];
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign scan_done = (state_r == S_SCAN) && (cnt_r == SCAN_LEN) && out_free;

  assign ctrl.insert = accept && (in_kind == KIND_LOCK) && (hold_r != '0) && !full;
  assign ctrl.clear  = scan_done && cd_valid[MAX_WAITERS];

  always_comb begin
    state_nxt     = state_r;
    hold_nxt      = hold_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    woken_nxt     = woken_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          woken_nxt = '0;
          if (in_kind == KIND_LOCK) begin
            out_valid_nxt = 1'b1;
            if (hold_r == '0) begin
              hold_nxt   = HOLD_ONE;
              status_nxt = ST_GRANTED;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              hold_nxt   = hold_r + HOLD_ONE;
              status_nxt = ST_QUEUED;
            end
          end else begin
            if (hold_r == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_UNBALANCED;
            end else if (hold_r == HOLD_ONE) begin
              out_valid_nxt = 1'b1;
              hold_nxt      = '0;
              status_nxt    = ST_FREED;
            end else begin
              hold_nxt  = hold_r - HOLD_ONE;
              cnt_nxt   = '0;
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (cnt_r != SCAN_LEN) begin
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end
        if (scan_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (cd_valid[MAX_WAITERS]) begin
            status_nxt = ST_HANDED;
            woken_nxt  = cd_id[MAX_WAITERS];
          end else begin
            status_nxt = ST_FREED;
            woken_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hold_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hold_r      <= hold_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    woken_r  <= woken_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_woken_thread = woken_r;

  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(hold_r) <= MAX_WAITERS + 1)
    else $error("hold count beyond owner plus table size");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.insert |-> !full)
    else $error("insert into a full wait chain");

  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && hold_r == '0) |-> ($countones(ch_valid[MAX_WAITERS:1]) == 0))
    else $error("waiters present while mutex is free");

  a_hold_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && hold_r != '0) |->
      ($countones(ch_valid[MAX_WAITERS:1]) == int'(hold_r) - 1))
    else $error("hold count out of step with waiter count");

  a_scan_finds: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> cd_valid[MAX_WAITERS])
    else $error("hand-over scan found no waiter");

endmodule
